@@ rtl/core/lfp_pkg.sv @@
// lfp_pkg: shared types and constants of the lidar frame parser
// used by lfp_decode and lidar_frame_parser_top; no dependencies
`timescale 1ns / 1ps

package lfp_pkg;

    // frame geometry
    localparam int FRAME_LEN = 9;
    localparam int HEAD_LEN  = FRAME_LEN - 1;
    localparam int IDX_W     = 4;
    localparam int SENSOR_W  = 3;

    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] FIRST_IDX   = IDX_W'(0);
    // byte positions that carry a reply checksum
    localparam logic [IDX_W-1:0] CHK_RATE_IDX    = IDX_W'(5);
    localparam logic [IDX_W-1:0] CHK_VERSION_IDX = IDX_W'(6);
    localparam logic [IDX_W-1:0] CHK_BAUD_IDX    = IDX_W'(7);

    // frame headers
    localparam logic [7:0] HDR_MEAS = 8'h59;
    localparam logic [7:0] HDR_CMD  = 8'h5A;

    // defaults and limits
    localparam logic [15:0] STRENGTH_SAT     = 16'hFFFF;
    localparam logic [15:0] DEF_MIN_STRENGTH = 16'd100;
    localparam logic [15:0] DEF_FRAME_RATE   = 16'd100;
    localparam logic [31:0] DEF_BAUD_RATE    = 32'd115200;

    // reported distance codes
    localparam logic [16:0] DIST_STALE = 17'h1FFFE;
    localparam logic [16:0] DIST_WEAK  = 17'h1FFFF;

    // stream widths
    localparam int S_TDATA_W   = 8;
    localparam int S_TUSER_W   = 4;
    localparam int M_TUSER_W   = 8;
    localparam int M_TDATA_USE = 147;
    localparam int M_TDATA_W   = 152;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        RK_FRAME      = 2'd0,
        RK_READ       = 2'd1,
        RK_BAD_SENSOR = 2'd2
    } result_kind_t;

    typedef enum logic [2:0] {
        FC_REJECT  = 3'd0,
        FC_MEAS    = 3'd1,
        FC_VERSION = 3'd2,
        FC_RATE    = 3'd3,
        FC_BAUD    = 3'd4,
        FC_FORMAT  = 3'd5,
        FC_ACK     = 3'd6
    } frame_class_t;

    typedef enum logic [1:0] {
        FMT_STD_CM  = 2'd0,
        FMT_PIXHAWK = 2'd1,
        FMT_STD_MM  = 2'd2
    } out_format_t;

    // checksum results gathered while the frame came in
    typedef struct packed {
        logic ok_rate;
        logic ok_version;
        logic ok_baud;
        logic ok_meas;
    } chk_t;

    // what a completed frame does to the sensor state
    typedef struct packed {
        frame_class_t cls;
        logic         upd_meas;
        logic         upd_version;
        logic         upd_rate;
        logic         upd_baud;
        logic         upd_format;
        out_format_t  format_val;
        logic         factory;
    } dec_t;

endpackage

@@ rtl/core/lidar_frame_parser_top.sv @@
// lidar_frame_parser_top: per-sensor UART frame parser for a range lidar
// Input beat: one received byte or a read request for one sensor. Every ninth
// byte of a sensor completes a frame and gives one result beat; a read request
// gives one result beat with the last measurement and marks it stale; a beat
// for a sensor at or above NUM_SENSORS gives an error result.
// Channels: s_* carries input beats, m_* result beats, cfg_wr_* sets the
// least strength for a valid read.
// Path: an accepted input beat passes the input register, then the state
// update writes the result register that drives m_tvalid.
// Throughput: one beat per cycle unless the result side stalls; the per-sensor
// state is read, updated and written back in the same cycle, and checksums
// build up as bytes arrive so a completed frame decodes in the same cycle.
// Reset: aresetn low clears both registers and restores every sensor to its
// defaults (no measurement, frame rate 100, baud 115200, standard cm format).
// Stall: while m_tready is low the result register holds and s_tready drops
// once the input register is also full; no beat is lost or repeated.
// depends on lfp_pkg and lfp_decode
`timescale 1ns / 1ps

module lidar_frame_parser_top
    import lfp_pkg::*;
#(
    parameter int NUM_SENSORS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,    // min_strength
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,        // [7:0] rx_byte
    input  logic [S_TUSER_W-1:0] s_tuser,        // [0] command, [3:1] sensor
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [16:0] distance_out, [32:17] strength_out, [48:33] temperature_out,
    // [72:49] version_out, [88:73] framerate_out, [120:89] baudrate_out,
    // [122:121] format_out, [130:123] ack_count_out,
    // [146:131] frame_count_out, [151:147] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [1:0] result_kind, [4:2] frame_class, [7:5] sensor_echo
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int SEL_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    // input register
    logic                in_valid_reg;
    cmd_t                in_cmd_reg;
    logic [SENSOR_W-1:0] in_sensor_reg;
    logic [7:0]          in_byte_reg;

    // configuration register
    logic [15:0] min_strength_reg;

    // per-sensor state
    logic [IDX_W-1:0]         idx_reg      [NUM_SENSORS];
    logic                     dvalid_reg   [NUM_SENSORS];
    logic [15:0]              dist_reg     [NUM_SENSORS];
    logic [15:0]              strength_reg [NUM_SENSORS];
    logic [15:0]              temp_reg     [NUM_SENSORS];
    logic [23:0]              version_reg  [NUM_SENSORS];
    logic [15:0]              rate_reg     [NUM_SENSORS];
    logic [31:0]              baud_reg     [NUM_SENSORS];
    out_format_t              format_reg   [NUM_SENSORS];
    logic [7:0]               ack_reg      [NUM_SENSORS];
    logic [15:0]              fcount_reg   [NUM_SENSORS];
    logic [HEAD_LEN-1:0][7:0] fbytes_reg   [NUM_SENSORS];
    logic [7:0]               sum_reg      [NUM_SENSORS];
    logic [2:0]               chk_reg      [NUM_SENSORS];  // rate, version, baud

    // result register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    // datapath
    logic             known;
    logic [SEL_W-1:0] sel;
    logic             produce;
    logic             wr;
    logic [IDX_W-1:0] idx_eff;
    logic             is_last;
    logic             byte_match;
    chk_t             chk;
    dec_t             dec;
    logic [HEAD_LEN-1:0][7:0] head;

    logic [IDX_W-1:0] nx_idx;
    logic             nx_dvalid;
    logic [15:0]      nx_dist;
    logic [15:0]      nx_strength;
    logic [15:0]      nx_temp;
    logic [23:0]      nx_version;
    logic [15:0]      nx_rate;
    logic [31:0]      nx_baud;
    out_format_t      nx_format;
    logic [7:0]       nx_ack;
    logic [15:0]      nx_fcount;

    logic             has_res;
    result_kind_t     res_kind;
    frame_class_t     res_cls;
    logic [16:0]      res_dist;
    logic [15:0]      res_strength;
    logic [15:0]      res_temp;
    logic [M_TDATA_W-1:0] res_tdata;

    // handshakes
    assign produce  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || produce;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // sensor selection and frame position
    assign known      = {1'b0, in_sensor_reg} < (SENSOR_W + 1)'(NUM_SENSORS);
    assign sel        = in_sensor_reg[SEL_W-1:0];
    assign wr         = produce && known;
    assign idx_eff    = (idx_reg[sel] >= IDX_W'(FRAME_LEN)) ? FIRST_IDX : idx_reg[sel];
    assign is_last    = (idx_eff == LAST_IDX);
    assign byte_match = (sum_reg[sel] == in_byte_reg);
    assign head       = fbytes_reg[sel];

    assign chk.ok_rate    = chk_reg[sel][2];
    assign chk.ok_version = chk_reg[sel][1];
    assign chk.ok_baud    = chk_reg[sel][0];
    assign chk.ok_meas    = byte_match;

    lfp_decode u_decode (
        .head_bytes (head),
        .chk        (chk),
        .dec        (dec)
    );

    // state update and result for the beat in the input register
    always_comb begin
        nx_idx      = idx_eff;
        nx_dvalid   = dvalid_reg[sel];
        nx_dist     = dist_reg[sel];
        nx_strength = strength_reg[sel];
        nx_temp     = temp_reg[sel];
        nx_version  = version_reg[sel];
        nx_rate     = rate_reg[sel];
        nx_baud     = baud_reg[sel];
        nx_format   = format_reg[sel];
        nx_ack      = ack_reg[sel];
        nx_fcount   = fcount_reg[sel];
        has_res     = 1'b0;
        res_kind    = RK_FRAME;
        res_cls     = FC_REJECT;
        res_dist    = '0;
        res_strength = '0;
        res_temp    = '0;

        if (!known) begin
            has_res  = 1'b1;
            res_kind = RK_BAD_SENSOR;
        end else if (in_cmd_reg == CMD_BYTE) begin
            nx_idx = is_last ? FIRST_IDX : idx_eff + IDX_W'(1);
            if (is_last) begin
                has_res = 1'b1;
                res_cls = dec.cls;
                if (dec.upd_meas) begin
                    nx_dvalid   = 1'b1;
                    nx_dist     = {head[3], head[2]};
                    nx_strength = {head[5], head[4]};
                    nx_temp     = {head[7], head[6]};
                    nx_fcount   = fcount_reg[sel] + 16'd1;
                end
                if (dec.upd_version) begin
                    nx_version = {head[5], head[4], head[3]};
                end
                if (dec.upd_rate) begin
                    nx_rate = {head[4], head[3]};
                end
                if (dec.upd_baud) begin
                    nx_baud = {head[6], head[5], head[4], head[3]};
                end
                if (dec.upd_format) begin
                    nx_format = dec.format_val;
                end
                if (dec.factory) begin
                    nx_rate   = DEF_FRAME_RATE;
                    nx_baud   = DEF_BAUD_RATE;
                    nx_format = FMT_STD_CM;
                end
                if (dec.cls != FC_REJECT && dec.cls != FC_MEAS) begin
                    nx_ack = ack_reg[sel] + 8'd1;
                end
                res_dist     = nx_dvalid ? {1'b0, nx_dist} : DIST_STALE;
                res_strength = nx_strength;
                res_temp     = nx_temp;
            end
        end else begin
            // read of the last acquisition, then mark it stale
            has_res   = 1'b1;
            res_kind  = RK_READ;
            nx_dvalid = 1'b0;
            if (!dvalid_reg[sel]) begin
                res_dist = DIST_STALE;
            end else begin
                if (strength_reg[sel] >= min_strength_reg &&
                    strength_reg[sel] != STRENGTH_SAT) begin
                    res_dist = {1'b0, dist_reg[sel]};
                end else begin
                    res_dist = DIST_WEAK;
                end
                res_strength = strength_reg[sel];
                res_temp     = temp_reg[sel];
            end
        end
    end

    // result packing; error results carry zeros
    always_comb begin
        res_tdata = '0;
        if (known) begin
            res_tdata[M_TDATA_USE-1:0] = {nx_fcount, nx_ack, nx_format, nx_baud, nx_rate,
                                          nx_version, res_temp, res_strength, res_dist};
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_strength_reg <= DEF_MIN_STRENGTH;
        end else if (cfg_wr_en) begin
            min_strength_reg <= cfg_wr_data;
        end
    end

    // input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg    <= cmd_t'(s_tuser[0]);
            in_sensor_reg <= s_tuser[SENSOR_W:1];
            in_byte_reg   <= s_tdata;
        end
    end

    // per-sensor control and status state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                idx_reg[i]      <= FIRST_IDX;
                dvalid_reg[i]   <= 1'b0;
                dist_reg[i]     <= '0;
                strength_reg[i] <= '0;
                temp_reg[i]     <= '0;
                version_reg[i]  <= '0;
                rate_reg[i]     <= DEF_FRAME_RATE;
                baud_reg[i]     <= DEF_BAUD_RATE;
                format_reg[i]   <= FMT_STD_CM;
                ack_reg[i]      <= '0;
                fcount_reg[i]   <= '0;
            end
        end else if (wr) begin
            idx_reg[sel]      <= nx_idx;
            dvalid_reg[sel]   <= nx_dvalid;
            dist_reg[sel]     <= nx_dist;
            strength_reg[sel] <= nx_strength;
            temp_reg[sel]     <= nx_temp;
            version_reg[sel]  <= nx_version;
            rate_reg[sel]     <= nx_rate;
            baud_reg[sel]     <= nx_baud;
            format_reg[sel]   <= nx_format;
            ack_reg[sel]      <= nx_ack;
            fcount_reg[sel]   <= nx_fcount;
        end
    end

    // frame bytes, running sum and reply checksums
    always_ff @(posedge aclk) begin
        if (wr && in_cmd_reg == CMD_BYTE) begin
            if (!is_last) begin
                fbytes_reg[sel][idx_eff[2:0]] <= in_byte_reg;
            end
            sum_reg[sel] <= (idx_eff == FIRST_IDX) ? in_byte_reg : sum_reg[sel] + in_byte_reg;
            if (idx_eff == CHK_RATE_IDX) begin
                chk_reg[sel][2] <= byte_match;
            end
            if (idx_eff == CHK_VERSION_IDX) begin
                chk_reg[sel][1] <= byte_match;
            end
            if (idx_eff == CHK_BAUD_IDX) begin
                chk_reg[sel][0] <= byte_match;
            end
        end
    end

    // result register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (produce) begin
            m_tvalid_reg <= has_res;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (produce && has_res) begin
            m_tdata_reg <= res_tdata;
            m_tuser_reg <= {in_sensor_reg, res_cls, res_kind};
        end
    end

endmodule

@@ rtl/core/lfp_decode.sv @@
// lfp_decode: classifies a completed 9-byte frame and flags the state updates
// depends on lfp_pkg
`timescale 1ns / 1ps

module lfp_decode
    import lfp_pkg::*;
(
    input  logic [HEAD_LEN-1:0][7:0] head_bytes,  // bytes 0..7 of the frame
    input  chk_t                     chk,
    output dec_t                     dec
);

    function automatic logic tail_is(input logic [HEAD_LEN-1:0][7:0] b,
                                     input logic [7:0] c1, input logic [7:0] c2,
                                     input logic [7:0] c3, input logic [7:0] c4);
        return (b[1] == c1) && (b[2] == c2) && (b[3] == c3) && (b[4] == c4);
    endfunction

    // priority chain of the known replies
    always_comb begin
        dec = '0;
        dec.cls = FC_REJECT;
        dec.format_val = FMT_STD_CM;
        if (head_bytes[0] == HDR_MEAS) begin
            if (head_bytes[1] == HDR_MEAS && chk.ok_meas) begin
                dec.upd_meas = 1'b1;
                dec.cls = FC_MEAS;
            end
        end else if (head_bytes[0] == HDR_CMD) begin
            if (head_bytes[1] == 8'h07 && head_bytes[2] == 8'h01) begin
                if (chk.ok_version) begin
                    dec.upd_version = 1'b1;
                    dec.cls = FC_VERSION;
                end
            end else if (tail_is(head_bytes, 8'h05, 8'h02, 8'h00, 8'h60) ||
                         tail_is(head_bytes, 8'h05, 8'h02, 8'h01, 8'h61)) begin
                dec.cls = FC_ACK;
            end else if (head_bytes[1] == 8'h06 && head_bytes[2] == 8'h03) begin
                if (chk.ok_rate) begin
                    dec.upd_rate = 1'b1;
                    dec.cls = FC_RATE;
                end
            end else if (tail_is(head_bytes, 8'h05, 8'h05, 8'h01, 8'h65)) begin
                dec.upd_format = 1'b1;
                dec.format_val = FMT_STD_CM;
                dec.cls = FC_FORMAT;
            end else if (tail_is(head_bytes, 8'h05, 8'h05, 8'h02, 8'h66)) begin
                dec.upd_format = 1'b1;
                dec.format_val = FMT_PIXHAWK;
                dec.cls = FC_FORMAT;
            end else if (tail_is(head_bytes, 8'h05, 8'h05, 8'h03, 8'h67)) begin
                dec.upd_format = 1'b1;
                dec.format_val = FMT_STD_MM;
                dec.cls = FC_FORMAT;
            end else if (head_bytes[1] == 8'h08 && head_bytes[2] == 8'h06) begin
                if (chk.ok_baud) begin
                    dec.upd_baud = 1'b1;
                    dec.cls = FC_BAUD;
                end
            end else if (tail_is(head_bytes, 8'h05, 8'h07, 8'h00, 8'h66) ||
                         tail_is(head_bytes, 8'h05, 8'h07, 8'h01, 8'h67)) begin
                dec.cls = FC_ACK;
            end else if (tail_is(head_bytes, 8'h05, 8'h10, 8'h00, 8'h6E)) begin
                // factory reset acknowledged
                dec.factory = 1'b1;
                dec.cls = FC_ACK;
            end else if (tail_is(head_bytes, 8'h05, 8'h10, 8'h01, 8'h6F) ||
                         tail_is(head_bytes, 8'h05, 8'h22, 8'h00, 8'h6F) ||
                         tail_is(head_bytes, 8'h05, 8'h22, 8'h01, 8'h70)) begin
                dec.cls = FC_ACK;
            end
        end
    end

endmodule

@@ test/lfp_parser_scoreboard.sv @@
// lfp_test_pkg: reply codes and the result scoreboard for the lidar frame parser bench
// depends on lfp_pkg (types, headers, defaults and stream widths of the parser)
`timescale 1ns / 1ps

package lfp_test_pkg;
    import lfp_pkg::*;

    localparam int SENSOR_COUNT = 4;
    localparam int NO_MEAS      = -2;
    localparam int REPORT_LIMIT = 10;

    // reply length bytes
    localparam logic [7:0] LEN_STATUS  = 8'h05;
    localparam logic [7:0] LEN_RATE    = 8'h06;
    localparam logic [7:0] LEN_VERSION = 8'h07;
    localparam logic [7:0] LEN_BAUD    = 8'h08;

    // reply id bytes
    localparam logic [7:0] ID_VERSION    = 8'h01;
    localparam logic [7:0] ID_SYS_RESET  = 8'h02;
    localparam logic [7:0] ID_RATE       = 8'h03;
    localparam logic [7:0] ID_FORMAT     = 8'h05;
    localparam logic [7:0] ID_BAUD       = 8'h06;
    localparam logic [7:0] ID_OUT_ENABLE = 8'h07;
    localparam logic [7:0] ID_FACTORY    = 8'h10;
    localparam logic [7:0] ID_LOW_POWER  = 8'h22;

    // status replies as {id, value, check}
    localparam logic [7:0]  FORMAT_CHECK_BASE = 8'h64;
    localparam logic [23:0] FACTORY_DONE      = {ID_FACTORY, 8'h00, 8'h6E};
    localparam logic [23:0] PLAIN_ACKS [7] = '{
        {ID_SYS_RESET, 8'h00, 8'h60}, {ID_SYS_RESET, 8'h01, 8'h61},
        {ID_OUT_ENABLE, 8'h00, 8'h66}, {ID_OUT_ENABLE, 8'h01, 8'h67},
        {ID_FACTORY, 8'h01, 8'h6F}, {ID_LOW_POWER, 8'h00, 8'h6F},
        {ID_LOW_POWER, 8'h01, 8'h70}
    };

    // m_tdata fields, lowest bits last
    typedef struct packed {
        logic [15:0] frames;
        logic [7:0]  acks;
        logic [1:0]  fmt;
        logic [31:0] baud;
        logic [15:0] rate;
        logic [23:0] version;
        logic [15:0] temperature;
        logic [15:0] strength;
        logic [16:0] distance;
    } parser_status_t;

    // m_tuser fields, lowest bits last
    typedef struct packed {
        logic [2:0] sensor;
        logic [2:0] cls;
        logic [1:0] kind;
    } parser_tag_t;

    typedef struct packed {
        parser_tag_t    tag;
        parser_status_t data;
    } parser_result_t;

    class parser_scoreboard;
        logic [FRAME_LEN-1:0][7:0] rx_frame [SENSOR_COUNT];
        int unsigned               fill [SENSOR_COUNT];
        int                        last_dist [SENSOR_COUNT];
        logic [15:0]               last_str [SENSOR_COUNT];
        logic [15:0]               last_temp [SENSOR_COUNT];
        logic [23:0]               fw_ver [SENSOR_COUNT];
        logic [15:0]               rate [SENSOR_COUNT];
        logic [31:0]               baud [SENSOR_COUNT];
        logic [1:0]                fmt [SENSOR_COUNT];
        logic [7:0]                acks [SENSOR_COUNT];
        logic [15:0]               frames [SENSOR_COUNT];
        logic [15:0]               min_strength;
        parser_result_t            results_due [$];
        int                        mismatches;

        function new();
            for (int s = 0; s < SENSOR_COUNT; s++) begin
                rx_frame[s]  = '0;
                fill[s]      = 0;
                last_dist[s] = NO_MEAS;
                last_str[s]  = '0;
                last_temp[s] = '0;
                fw_ver[s]    = '0;
                rate[s]      = DEF_FRAME_RATE;
                baud[s]      = DEF_BAUD_RATE;
                fmt[s]       = FMT_STD_CM;
                acks[s]      = '0;
                frames[s]    = '0;
            end
            min_strength = DEF_MIN_STRENGTH;
            mismatches   = 0;
        endfunction

        // 8-bit sum of the first n bytes against byte n
        function bit sum_ok(logic [FRAME_LEN-1:0][7:0] f, int n);
            logic [7:0] acc;
            acc = '0;
            for (int k = 0; k < n; k++) acc += f[k];
            return acc == f[n];
        endfunction

        // apply a completed frame to the sensor state
        function frame_class_t decode_frame(int sn);
            logic [FRAME_LEN-1:0][7:0] b;
            logic [23:0]               tail;
            frame_class_t              cls;
            b    = rx_frame[sn];
            tail = {b[2], b[3], b[4]};
            cls  = FC_REJECT;
            if (b[0] == HDR_MEAS) begin
                if (b[1] == HDR_MEAS && sum_ok(b, 8)) begin
                    last_dist[sn] = int'({b[3], b[2]});
                    last_str[sn]  = {b[5], b[4]};
                    last_temp[sn] = {b[7], b[6]};
                    frames[sn]    = frames[sn] + 16'd1;
                    cls           = FC_MEAS;
                end
                return cls;
            end
            if (b[0] != HDR_CMD) return FC_REJECT;
            if (b[1] == LEN_VERSION && b[2] == ID_VERSION) begin
                if (sum_ok(b, 6)) begin
                    fw_ver[sn] = {b[5], b[4], b[3]};
                    cls        = FC_VERSION;
                end
            end else if (b[1] == LEN_RATE && b[2] == ID_RATE) begin
                if (sum_ok(b, 5)) begin
                    rate[sn] = {b[4], b[3]};
                    cls      = FC_RATE;
                end
            end else if (b[1] == LEN_BAUD && b[2] == ID_BAUD) begin
                if (sum_ok(b, 7)) begin
                    baud[sn] = {b[6], b[5], b[4], b[3]};
                    cls      = FC_BAUD;
                end
            end else if (b[1] == LEN_STATUS) begin
                if (b[2] == ID_FORMAT && b[3] inside {[8'd1:8'd3]} &&
                    b[4] == FORMAT_CHECK_BASE + b[3]) begin
                    case (b[3])
                        8'd1:    fmt[sn] = FMT_STD_CM;
                        8'd2:    fmt[sn] = FMT_PIXHAWK;
                        default: fmt[sn] = FMT_STD_MM;
                    endcase
                    cls = FC_FORMAT;
                end else if (tail == FACTORY_DONE) begin
                    // factory reset restores rate, baud and format
                    rate[sn] = DEF_FRAME_RATE;
                    baud[sn] = DEF_BAUD_RATE;
                    fmt[sn]  = FMT_STD_CM;
                    cls      = FC_ACK;
                end else begin
                    foreach (PLAIN_ACKS[i]) if (tail == PLAIN_ACKS[i]) cls = FC_ACK;
                end
            end
            if (cls != FC_REJECT) acks[sn] = acks[sn] + 8'd1;
            return cls;
        endfunction

        function parser_status_t with_status(int sn, parser_status_t d);
            d.version = fw_ver[sn];
            d.rate    = rate[sn];
            d.baud    = baud[sn];
            d.fmt     = fmt[sn];
            d.acks    = acks[sn];
            d.frames  = frames[sn];
            return d;
        endfunction

        // work out the result beat, if any, of an accepted input beat
        function void predict_beat(cmd_t cmd, logic [2:0] sn, logic [7:0] rx);
            parser_result_t r;
            int unsigned    idx;
            r            = '0;
            r.tag.sensor = sn;
            if (sn >= SENSOR_COUNT) begin
                r.tag.kind = RK_BAD_SENSOR;
                results_due.push_back(r);
                return;
            end
            if (cmd == CMD_BYTE) begin
                idx               = fill[sn];
                rx_frame[sn][idx] = rx;
                if (idx < FRAME_LEN - 1) begin
                    fill[sn] = idx + 1;
                    return;
                end
                fill[sn]    = 0;
                r.tag.kind  = RK_FRAME;
                r.tag.cls   = decode_frame(sn);
                r.data.distance    = last_dist[sn][16:0];
                r.data.strength    = last_str[sn];
                r.data.temperature = last_temp[sn];
            end else begin
                r.tag.kind = RK_READ;
                r.tag.cls  = FC_REJECT;
                if (last_dist[sn] == NO_MEAS) begin
                    r.data.distance = DIST_STALE;
                end else begin
                    if (last_str[sn] >= min_strength && last_str[sn] != STRENGTH_SAT)
                        r.data.distance = last_dist[sn][16:0];
                    else
                        r.data.distance = DIST_WEAK;
                    r.data.strength    = last_str[sn];
                    r.data.temperature = last_temp[sn];
                end
                // a read always leaves the measurement stale
                last_dist[sn] = NO_MEAS;
            end
            r.data = with_status(sn, r.data);
            results_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: %s wrong, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        // compare an accepted result beat with the oldest expectation
        function void check_beat(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            parser_result_t got;
            parser_result_t want;
            got.tag  = tuser;
            got.data = tdata[M_TDATA_USE-1:0];
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result beat with none expected, tuser %0h tdata %0h",
                             $time, tuser, tdata);
                return;
            end
            want = results_due.pop_front();
            compare_field("result_kind", want.tag.kind, got.tag.kind);
            compare_field("frame_class", want.tag.cls, got.tag.cls);
            compare_field("sensor_echo", want.tag.sensor, got.tag.sensor);
            compare_field("distance_out", want.data.distance, got.data.distance);
            compare_field("strength_out", want.data.strength, got.data.strength);
            compare_field("temperature_out", want.data.temperature, got.data.temperature);
            compare_field("version_out", want.data.version, got.data.version);
            compare_field("framerate_out", want.data.rate, got.data.rate);
            compare_field("baudrate_out", want.data.baud, got.data.baud);
            compare_field("format_out", want.data.fmt, got.data.fmt);
            compare_field("ack_count_out", want.data.acks, got.data.acks);
            compare_field("frame_count_out", want.data.frames, got.data.frames);
        endfunction
    endclass

endpackage

@@ test/lidar_frame_parser_top_test.sv @@
// lidar_frame_parser_top_test: drives byte and read beats into the frame parser
// with random gaps and stalls and checks every result beat on the scoreboard
// depends on lfp_pkg, lfp_test_pkg and lidar_frame_parser_top
`timescale 1ns / 1ps

module lidar_frame_parser_top_test;
    import lfp_pkg::*;
    import lfp_test_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int PHASES       = 5;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 6;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [15:0]          cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    parser_scoreboard sb;
    bit               tx_gaps;
    bit               rx_gaps;
    bit               hold_req;

    // per-sensor frame being sent and byte position modulo nine
    logic [FRAME_LEN-1:0][7:0] next_frame [SENSOR_COUNT];
    int unsigned               frame_pos [SENSOR_COUNT];
    int unsigned               align [SENSOR_COUNT];

    lidar_frame_parser_top #(
        .NUM_SENSORS(SENSOR_COUNT)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // run limit
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // one input beat, after a random gap
    task automatic send_item(input logic cmd, input logic [2:0] sn, input logic [7:0] rx);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 15) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = {sn, cmd};
        s_tdata  = rx;
        do @(posedge aclk); while (!s_tready);
        sb.predict_beat(cmd_t'(cmd), sn, rx);
    endtask

    task automatic send_frame(input logic [2:0] sn, input logic [FRAME_LEN-1:0][7:0] f);
        for (int k = 0; k < FRAME_LEN; k++) send_item(CMD_BYTE, sn, f[k]);
    endtask

    // stop sending and let every expected result and the pipeline drain
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_min_strength(input logic [15:0] value);
        drain();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.min_strength = value;
    endtask

    function automatic logic [FRAME_LEN-1:0][7:0] with_checksum(
        input logic [FRAME_LEN-1:0][7:0] f, input int n);
        logic [7:0] acc;
        acc = '0;
        for (int k = 0; k < n; k++) acc += f[k];
        f[n] = acc;
        return f;
    endfunction

    // well-formed frames of every kind, with some corruption and some junk
    function automatic logic [FRAME_LEN-1:0][7:0] random_frame();
        logic [FRAME_LEN-1:0][7:0] f;
        int                        chk;
        chk = 0;
        for (int k = 0; k < FRAME_LEN; k++) f[k] = 8'($urandom);
        f[0] = HDR_CMD;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 16, 17, 18: begin
                f[0] = HDR_MEAS;
                f[1] = HDR_MEAS;
                case ($urandom_range(0, 3))
                    0: {f[5], f[4]} = STRENGTH_SAT;
                    1: {f[5], f[4]} = sb.min_strength + 16'($urandom_range(0, 2)) - 16'd1;
                    2: {f[5], f[4]} = 16'($urandom_range(0, 255));
                    default: ;
                endcase
                if ($urandom_range(0, 3) == 0)
                    {f[3], f[2]} = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                chk = 8;
            end
            6: begin
                f[1] = LEN_VERSION;
                f[2] = ID_VERSION;
                chk  = 6;
            end
            7: begin
                f[1] = LEN_RATE;
                f[2] = ID_RATE;
                chk  = 5;
            end
            8: begin
                f[1] = LEN_BAUD;
                f[2] = ID_BAUD;
                chk  = 7;
            end
            9: begin
                f[1] = LEN_STATUS;
                f[2] = ID_FORMAT;
                f[3] = 8'($urandom_range(1, 3));
                f[4] = FORMAT_CHECK_BASE + f[3];
            end
            10: begin
                f[1]               = LEN_STATUS;
                {f[2], f[3], f[4]} = FACTORY_DONE;
            end
            11: begin
                f[1]               = LEN_STATUS;
                {f[2], f[3], f[4]} = PLAIN_ACKS[$urandom_range(0, 6)];
            end
            12: begin
                // status reply close to a known one
                f[1] = LEN_STATUS;
                f[2] = $urandom_range(0, 1) ? ID_FORMAT : PLAIN_ACKS[$urandom_range(0, 6)][23:16];
                f[3] = 8'($urandom_range(0, 3));
                f[4] = 8'($urandom_range(8'h5F, 8'h71));
            end
            13: f[0] = 8'($urandom);
            14: f[0] = HDR_MEAS;
            default: ;
        endcase
        if (chk != 0) begin
            f = with_checksum(f, chk);
            if ($urandom_range(0, 7) == 0) f[chk] = f[chk] ^ 8'($urandom_range(1, 255));
        end
        return f;
    endfunction

    // one random beat: mostly frame bytes kept in alignment, plus reads and noise
    task automatic random_item();
        int         roll;
        logic [2:0] sn;
        logic [7:0] rx;
        roll = $urandom_range(0, 99);
        sn   = 3'($urandom_range(0, SENSOR_COUNT - 1));
        if (roll < 4) begin
            send_item(1'($urandom), 3'($urandom_range(SENSOR_COUNT, 7)), 8'($urandom));
        end else if (roll < 13) begin
            send_item(CMD_READ, sn, 8'($urandom));
        end else begin
            rx = 8'($urandom);
            if (roll >= 16) begin
                if (frame_pos[sn] >= FRAME_LEN && align[sn] == 0) begin
                    next_frame[sn] = random_frame();
                    frame_pos[sn]  = 0;
                end
                // pad bytes realign a sensor after noise
                if (frame_pos[sn] < FRAME_LEN) begin
                    rx = next_frame[sn][frame_pos[sn]];
                    frame_pos[sn]++;
                end
            end
            send_item(CMD_BYTE, sn, rx);
            align[sn] = (align[sn] + 1) % FRAME_LEN;
        end
    endtask

    // result side: random stalls and one long hold on request
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = rx_gaps ? $urandom_range(0, 15) : 0;
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_beat(m_tdata, m_tuser);
            @(negedge aclk);
        end
    end

    // stimulus
    initial begin : stimulus
        logic [15:0] setting;
        sb          = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        hold_req    = 1'b0;
        for (int s = 0; s < SENSOR_COUNT; s++) begin
            next_frame[s] = '0;
            frame_pos[s]  = FRAME_LEN;
            align[s]      = 0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: stale read, unknown sensor, threshold, saturated strength
        send_item(CMD_READ, 3'd0, 8'h00);
        send_item(CMD_BYTE, 3'd7, 8'hFF);
        send_item(CMD_READ, 3'd4, 8'hA5);
        send_frame(3'd1, with_checksum({8'h00, 16'h0ABC, DEF_MIN_STRENGTH, 16'hFFFF,
                                        HDR_MEAS, HDR_MEAS}, 8));
        send_item(CMD_READ, 3'd1, 8'h00);
        send_item(CMD_READ, 3'd1, 8'hFF);
        send_frame(3'd2, with_checksum({8'h00, 16'hFFFF, STRENGTH_SAT, 16'h0000,
                                        HDR_MEAS, HDR_MEAS}, 8));
        send_item(CMD_READ, 3'd2, 8'h5A);

        // random phases, each with its own strength threshold
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                case (ph)
                    1:       setting = 16'h0000;
                    2:       setting = 16'hFFFF;
                    3:       setting = 16'($urandom);
                    default: setting = 16'd1;
                endcase
                set_min_strength(setting);
            end
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                if (n % 64 == 0) begin
                    tx_gaps = $urandom_range(0, 2) != 0;
                    rx_gaps = $urandom_range(0, 2) != 0;
                end
                // back pressure: hold the result side while reads keep coming
                if (ph == 1 && n == 100) begin
                    hold_req = 1'b1;
                    tx_gaps  = 1'b0;
                    repeat (40) send_item(CMD_READ, 3'($urandom_range(0, SENSOR_COUNT - 1)),
                                          8'($urandom));
                end
                random_item();
            end
        end

        drain();
        if (sb.mismatches == 0 && sb.results_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
